// File: sv/krt_pkg.sv
package krt_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_BITS = 64;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam int S_DATA_W = 144;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 144;

	localparam logic [1:0] CMD_SET     = 2'd0;
	localparam logic [1:0] CMD_LOOKUP  = 2'd1;
	localparam logic [1:0] CMD_SESSION = 2'd2;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [31:0]         weight;
		logic [7:0]          reps;
		logic [31:0]         stamp;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_FIN
	} state_t;

endpackage

// File: sv/keyed_record_table_oldest_eviction.sv
// channel  dir  signals                      fields (lowest bit up)
// s        in   s_tvalid s_tready s_tdata     key, weight_word, rep_count, now_time, clock_ok
//               s_tuser                       cmd
// m        out  m_tvalid m_tready m_tdata     hit, stored_weight, stored_reps, stored_time,
//                                             evicted, entries_in_use, sets_total, sessions_total
// entries ring through CAPACITY cells past a head cell, one place per cycle in scan and shift
// lookup and record hit: a scan lap of the ring; record miss: a scan lap, then an insertion lap
// session and unused codes: straight to the result; one item at a time, s_tready high only when idle
// the result sits in an output register, so the next beat is taken while it waits
// arst_n clears counters and control; cell contents stay undefined until written
module keyed_record_table_oldest_eviction (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// key, weight_word, rep_count, now_time, clock_ok, zero pad
	input  logic [krt_pkg::S_DATA_W-1:0]  s_tdata,
	// cmd
	input  logic [krt_pkg::S_USER_W-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// hit, stored_weight, stored_reps, stored_time, evicted, entries_in_use,
	// sets_total, sessions_total, zero pad
	output logic [krt_pkg::M_DATA_W-1:0]  m_tdata
);

	krt_pkg::state_t state_q, state_d;

	logic [krt_pkg::IDX_W-1:0] step_q;
	logic [krt_pkg::CNT_W-1:0] used_q;
	logic [31:0]               sets_q;
	logic [31:0]               sess_q;
	logic                      m_tvalid_q;
	logic [krt_pkg::M_DATA_W-1:0] m_tdata_q;

	logic [1:0]                cmd_q;
	krt_pkg::entry_t           new_q;
	krt_pkg::entry_t           carry_q;
	logic                      hit_q;
	logic                      evict_q;
	logic [31:0]               min_q;
	logic [krt_pkg::IDX_W-1:0] old_q;
	logic [31:0]               res_w_q;
	logic [7:0]                res_r_q;
	logic [31:0]               res_t_q;

	krt_pkg::entry_t cell_q [krt_pkg::CAPACITY];
	krt_pkg::entry_t head;
	krt_pkg::entry_t tail;

	logic                      accept;
	logic                      shift_en;
	logic                      last_step;
	logic [krt_pkg::CNT_W-1:0] step_ext;
	logic                      in_use;
	logic                      match;
	logic                      hit_now;
	logic                      full;
	logic [krt_pkg::CNT_W-1:0] cut;
	logic                      out_free;
	logic [krt_pkg::CNT_W+4:0] used_wide;
	logic [31:0]               in_stamp;

	// ring of cells, head at position 0, tail fed by the control logic
	for (genvar i = 0; i < krt_pkg::CAPACITY; i++) begin : g_cell
		if (i == krt_pkg::CAPACITY - 1) begin : g_tail
			krt_cell u_cell (
				.clk   (clk),
				.shift (shift_en),
				.d     (tail),
				.q     (cell_q[i])
			);
		end else begin : g_mid
			krt_cell u_cell (
				.clk   (clk),
				.shift (shift_en),
				.d     (cell_q[i+1]),
				.q     (cell_q[i])
			);
		end
	end

	assign head      = cell_q[0];
	assign s_tready  = (state_q == krt_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign shift_en  = (state_q == krt_pkg::ST_SCAN) || (state_q == krt_pkg::ST_SHIFT);
	assign last_step = (step_q == krt_pkg::IDX_W'(krt_pkg::CAPACITY - 1));
	assign step_ext  = krt_pkg::CNT_W'(step_q);
	assign in_use    = (step_ext < used_q);
	assign match     = in_use && !hit_q && (head.key == new_q.key);
	assign hit_now   = hit_q || match;
	assign full      = (used_q == krt_pkg::CNT_W'(krt_pkg::CAPACITY));
	// position dropped on the insertion lap: the oldest when full, else the first free one
	assign cut       = full ? krt_pkg::CNT_W'(old_q) : used_q;
	assign out_free  = !m_tvalid_q || m_tready;
	assign used_wide = {5'd0, used_q};
	assign in_stamp  = s_tdata[136] ? s_tdata[135:104] : 32'd0;

	always_comb begin
		tail = head;
		case (state_q)
			krt_pkg::ST_SCAN: begin
				if (match && cmd_q == krt_pkg::CMD_SET) begin
					tail = new_q;
				end
			end
			krt_pkg::ST_SHIFT: begin
				if (step_ext <= cut) begin
					tail = (step_q == '0) ? new_q : carry_q;
				end
			end
			default: tail = head;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			krt_pkg::ST_IDLE: begin
				if (accept) begin
					if (s_tuser == krt_pkg::CMD_SET || s_tuser == krt_pkg::CMD_LOOKUP) begin
						state_d = krt_pkg::ST_SCAN;
					end else begin
						state_d = krt_pkg::ST_FIN;
					end
				end
			end
			krt_pkg::ST_SCAN: begin
				if (last_step) begin
					state_d = (cmd_q == krt_pkg::CMD_SET && !hit_now) ?
						krt_pkg::ST_SHIFT : krt_pkg::ST_FIN;
				end
			end
			krt_pkg::ST_SHIFT: begin
				if (last_step) begin
					state_d = krt_pkg::ST_FIN;
				end
			end
			krt_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = krt_pkg::ST_IDLE;
				end
			end
			default: state_d = krt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= krt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= '0;
			used_q     <= '0;
			sets_q     <= '0;
			sess_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == krt_pkg::ST_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				krt_pkg::ST_IDLE: begin
					step_q <= '0;
					if (accept && s_tuser == krt_pkg::CMD_SET) begin
						sets_q <= sets_q + 32'd1;
					end
					if (accept && s_tuser == krt_pkg::CMD_SESSION) begin
						sess_q <= sess_q + 32'd1;
					end
				end
				krt_pkg::ST_SCAN: begin
					step_q <= last_step ? '0 : step_q + 1'b1;
				end
				krt_pkg::ST_SHIFT: begin
					step_q <= last_step ? '0 : step_q + 1'b1;
					if (last_step && !full) begin
						used_q <= used_q + 1'b1;
					end
				end
				krt_pkg::ST_FIN: ;
				default: step_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			krt_pkg::ST_IDLE: begin
				if (accept) begin
					cmd_q        <= s_tuser;
					new_q.key    <= s_tdata[krt_pkg::KEY_BITS-1:0];
					new_q.weight <= s_tdata[95:64];
					new_q.reps   <= s_tdata[103:96];
					new_q.stamp  <= in_stamp;
					hit_q        <= 1'b0;
					evict_q      <= 1'b0;
					if (s_tuser == krt_pkg::CMD_SET) begin
						res_w_q <= s_tdata[95:64];
						res_r_q <= s_tdata[103:96];
						res_t_q <= in_stamp;
					end else begin
						res_w_q <= '0;
						res_r_q <= '0;
						res_t_q <= '0;
					end
				end
			end
			krt_pkg::ST_SCAN: begin
				if (match) begin
					hit_q <= 1'b1;
					if (cmd_q == krt_pkg::CMD_LOOKUP) begin
						res_w_q <= head.weight;
						res_r_q <= head.reps;
						res_t_q <= head.stamp;
					end
				end
				// oldest entry, lowest position wins a tie
				if (in_use && (step_q == '0 || head.stamp < min_q)) begin
					min_q <= head.stamp;
					old_q <= step_q;
				end
			end
			krt_pkg::ST_SHIFT: begin
				if (step_ext <= cut) begin
					carry_q <= head;
				end
				if (step_q == '0) begin
					evict_q <= full;
				end
			end
			krt_pkg::ST_FIN: begin
				if (out_free) begin
					m_tdata_q <= {1'b0, sess_q, sets_q, used_wide[4:0], evict_q,
						res_t_q, res_r_q, res_w_q, hit_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: sv/krt_cell.sv
module krt_cell (
	input  logic            clk,
	input  logic            shift,
	input  krt_pkg::entry_t d,
	output krt_pkg::entry_t q
);

	krt_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule
